[rtl/core/ahcc_pkg.sv]
// Shared constants, types and helper functions for the alphanumeric histogram cover check.
package ahcc_pkg;

	// Saturation point of every bin, every string length and the missing total.
	localparam int unsigned MAX_LEN  = 1024;
	localparam int unsigned NUM_BINS = 62;
	localparam int unsigned BIN_W    = $clog2(NUM_BINS);
	localparam int unsigned CNT_W    = $clog2(MAX_LEN + 1);
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned AMOUNT_W = 12;
	localparam int unsigned DIFF_W   = (CNT_W + 1 > AMOUNT_W) ? CNT_W + 1 : AMOUNT_W;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

	// Character ranges and the offsets that map them onto bins.
	localparam logic [CHAR_W-1:0] CH_DIGIT_LO = 8'd48;
	localparam logic [CHAR_W-1:0] CH_DIGIT_HI = 8'd57;
	localparam logic [CHAR_W-1:0] CH_LOWER_LO = 8'd97;
	localparam logic [CHAR_W-1:0] CH_LOWER_HI = 8'd122;
	localparam logic [CHAR_W-1:0] CH_UPPER_LO = 8'd65;
	localparam logic [CHAR_W-1:0] CH_UPPER_HI = 8'd90;
	localparam logic [CHAR_W-1:0] OFS_DIGIT   = 8'd48;
	localparam logic [CHAR_W-1:0] OFS_LOWER   = 8'd87;
	localparam logic [CHAR_W-1:0] OFS_UPPER   = 8'd29;

	typedef struct packed {
		logic             hit;
		logic [BIN_W-1:0] bin;
	} bin_info_t;

	// Digits land in bins 0..9, lower case in 10..35, upper case in 36..61.
	function automatic bin_info_t bin_of(input logic [CHAR_W-1:0] ch);
		bin_info_t r;
		r.hit = 1'b0;
		r.bin = '0;
		if (ch >= CH_DIGIT_LO && ch <= CH_DIGIT_HI) begin
			r.hit = 1'b1;
			r.bin = BIN_W'(ch - OFS_DIGIT);
		end else if (ch >= CH_LOWER_LO && ch <= CH_LOWER_HI) begin
			r.hit = 1'b1;
			r.bin = BIN_W'(ch - OFS_LOWER);
		end else if (ch >= CH_UPPER_LO && ch <= CH_UPPER_HI) begin
			r.hit = 1'b1;
			r.bin = BIN_W'(ch - OFS_UPPER);
		end
		return r;
	endfunction

	// Counts stop at the saturation point and hold there.
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v < MAX_CNT) ? v + CNT_W'(1) : MAX_CNT;
	endfunction

endpackage

[rtl/core/ahcc_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module ahcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/alnum_histogram_cover_check.sv]
// Top level of the alphanumeric histogram cover check.
//
// The block takes one character transaction per cycle while it is loading, each
// tagged as part of the offered or the wanted string, and keeps a 62-bin
// histogram of digits, lower case and upper case letters for each string plus a
// length per string, all saturating at MAX_LEN. Each histogram lives in its own
// RAM with a registered read; a character is read in the cycle it is accepted
// and written back in the next, and a one-entry forwarding register covers a
// character that hits the same bin as the one just before it, so character
// transactions sustain one per cycle while loading. A finish transaction closes
// input and starts a walk over the bins that reads both RAMs at one address per
// cycle; after the walk the done state waits for the last read and for room in
// the output register, gives the verdict and only then accepts the next
// character. The verdict waits in an output register until it is taken. Per-bin
// valid bits stand in for clearing the RAMs, so reset and each verdict empty
// both histograms at once without a clearing pass.
module alnum_histogram_cover_check (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [ahcc_pkg::CHAR_W-1:0]           char_code,
	input  logic                                  string_select,
	input  logic                                  finish,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  enough,
	output logic signed [ahcc_pkg::AMOUNT_W-1:0]  amount
);

	import ahcc_pkg::*;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_WALK,
		ST_DONE
	} state_t;

	state_t state_q;

	// Input side.
	logic      in_acc;
	logic      chr_acc;
	logic      fin_acc;
	bin_info_t in_info;

	// Histogram RAM ports; both RAMs always read the same bin.
	logic [BIN_W-1:0] rd_addr;
	logic [CNT_W-1:0] off_rdata;
	logic [CNT_W-1:0] wnt_rdata;
	logic             off_we;
	logic             wnt_we;

	// A bin whose valid bit is clear reads as zero.
	logic [NUM_BINS-1:0] off_vld_q;
	logic [NUM_BINS-1:0] wnt_vld_q;

	logic [CNT_W-1:0] off_len_q;
	logic [CNT_W-1:0] wnt_len_q;

	// Character stage: the read is in flight, the write-back happens here.
	logic             chr_vld_s1;
	logic             chr_sel_s1;
	logic             chr_hit_s1;
	logic [BIN_W-1:0] chr_bin_s1;

	// The last write, for a character that read the same bin in that cycle.
	logic             fwd_vld_q;
	logic             fwd_sel_q;
	logic [BIN_W-1:0] fwd_bin_q;
	logic [CNT_W-1:0] fwd_data_q;

	logic             fwd_hit;
	logic             sel_bin_vld;
	logic [CNT_W-1:0] sel_rdata;
	logic [CNT_W-1:0] cur_cnt;
	logic [CNT_W-1:0] upd_cnt;
	logic             wr_en;

	// Walk over the bins.
	logic [BIN_W-1:0] walk_idx_q;
	logic             walk_vld_s1;
	logic [BIN_W-1:0] walk_idx_s1;
	logic [CNT_W-1:0] missing_q;
	logic [CNT_W-1:0] walk_off;
	logic [CNT_W-1:0] walk_wnt;
	logic [CNT_W-1:0] surplus;
	logic [CNT_W:0]   missing_sum;
	logic [CNT_W-1:0] missing_nxt;

	// Verdict.
	logic                out_valid_q;
	logic                enough_q;
	logic [AMOUNT_W-1:0] amount_q;
	logic                out_free;
	logic                emit;
	logic [DIFF_W-1:0]   len_diff;
	logic [DIFF_W-1:0]   missing_ext;

	assign in_ready = (state_q == ST_LOAD);
	assign in_acc   = in_valid && in_ready;
	assign chr_acc  = in_acc && !finish;
	assign fin_acc  = in_acc && finish;
	assign in_info  = bin_of(char_code);

	assign rd_addr = (state_q == ST_WALK) ? walk_idx_q : in_info.bin;

	// Read-modify-write of the character's bin, with the previous write forwarded.
	assign fwd_hit     = fwd_vld_q && (fwd_sel_q == chr_sel_s1) && (fwd_bin_q == chr_bin_s1);
	assign sel_rdata   = chr_sel_s1 ? wnt_rdata : off_rdata;
	assign sel_bin_vld = chr_sel_s1 ? wnt_vld_q[chr_bin_s1] : off_vld_q[chr_bin_s1];
	assign cur_cnt     = fwd_hit ? fwd_data_q : (sel_bin_vld ? sel_rdata : '0);
	assign upd_cnt     = sat_inc(cur_cnt);
	assign wr_en       = chr_vld_s1 && chr_hit_s1;
	assign off_we      = wr_en && !chr_sel_s1;
	assign wnt_we      = wr_en && chr_sel_s1;

	ahcc_ram #(
		.WIDTH (CNT_W),
		.DEPTH (NUM_BINS)
	) u_off_ram (
		.clk   (clk),
		.we    (off_we),
		.waddr (chr_bin_s1),
		.wdata (upd_cnt),
		.raddr (rd_addr),
		.rdata (off_rdata)
	);

	ahcc_ram #(
		.WIDTH (CNT_W),
		.DEPTH (NUM_BINS)
	) u_wnt_ram (
		.clk   (clk),
		.we    (wnt_we),
		.waddr (chr_bin_s1),
		.wdata (upd_cnt),
		.raddr (rd_addr),
		.rdata (wnt_rdata)
	);

	// One bin of the walk: add the wanted surplus, saturating.
	assign walk_off    = off_vld_q[walk_idx_s1] ? off_rdata : '0;
	assign walk_wnt    = wnt_vld_q[walk_idx_s1] ? wnt_rdata : '0;
	assign surplus     = (walk_wnt > walk_off) ? walk_wnt - walk_off : '0;
	assign missing_sum = {1'b0, missing_q} + {1'b0, surplus};
	assign missing_nxt = (missing_sum > {1'b0, MAX_CNT}) ? MAX_CNT : missing_sum[CNT_W-1:0];

	// Length difference wraps modulo the width of the amount field.
	assign len_diff    = DIFF_W'(off_len_q) - DIFF_W'(wnt_len_q);
	assign missing_ext = DIFF_W'(missing_q);

	assign out_free = !out_valid_q || out_ready;
	assign emit     = (state_q == ST_DONE) && !walk_vld_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			walk_idx_q  <= '0;
			walk_vld_s1 <= 1'b0;
			chr_vld_s1  <= 1'b0;
			fwd_vld_q   <= 1'b0;
			off_vld_q   <= '0;
			wnt_vld_q   <= '0;
			off_len_q   <= '0;
			wnt_len_q   <= '0;
			missing_q   <= '0;
			out_valid_q <= 1'b0;
			enough_q    <= 1'b0;
			amount_q    <= '0;
		end else begin
			chr_vld_s1  <= chr_acc;
			fwd_vld_q   <= wr_en;
			walk_vld_s1 <= (state_q == ST_WALK);

			if (out_valid_q && out_ready && !emit) begin
				out_valid_q <= 1'b0;
			end

			if (chr_acc) begin
				if (string_select) begin
					wnt_len_q <= sat_inc(wnt_len_q);
				end else begin
					off_len_q <= sat_inc(off_len_q);
				end
			end

			if (off_we) begin
				off_vld_q[chr_bin_s1] <= 1'b1;
			end
			if (wnt_we) begin
				wnt_vld_q[chr_bin_s1] <= 1'b1;
			end

			if (walk_vld_s1) begin
				missing_q <= missing_nxt;
			end

			unique case (state_q)
				ST_LOAD: begin
					if (fin_acc) begin
						state_q    <= ST_WALK;
						walk_idx_q <= '0;
						missing_q  <= '0;
					end
				end
				ST_WALK: begin
					if (walk_idx_q == BIN_W'(NUM_BINS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						walk_idx_q <= walk_idx_q + BIN_W'(1);
					end
				end
				ST_DONE: begin
					if (emit) begin
						out_valid_q <= 1'b1;
						enough_q    <= (missing_q == '0);
						amount_q    <= (missing_q == '0) ? len_diff[AMOUNT_W-1:0]
						                                 : missing_ext[AMOUNT_W-1:0];
						off_vld_q   <= '0;
						wnt_vld_q   <= '0;
						off_len_q   <= '0;
						wnt_len_q   <= '0;
						state_q     <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Payload of the pipeline stages; the valid bits above qualify them.
	always_ff @(posedge clk) begin
		chr_sel_s1  <= string_select;
		chr_hit_s1  <= in_info.hit;
		chr_bin_s1  <= in_info.bin;
		walk_idx_s1 <= walk_idx_q;
		fwd_sel_q   <= chr_sel_s1;
		fwd_bin_q   <= chr_bin_s1;
		fwd_data_q  <= upd_cnt;
	end

	assign out_valid = out_valid_q;
	assign enough    = enough_q;
	assign amount    = signed'(amount_q);

	// A character write-back and a walk read never share the stage after the RAMs.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(chr_vld_s1 && walk_vld_s1))
		else $error("character and walk both in stage one");

	// The walk starts only after the last character has been written back.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> !chr_vld_s1)
		else $error("walk overlaps a pending character write");

	// The missing total never passes the saturation point.
	assert property (@(posedge clk) disable iff (!arst_n)
		missing_q <= MAX_CNT)
		else $error("missing total above saturation");

	// A new verdict appears only out of the done state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("verdict raised outside the done state");

endmodule
